// ===== design/dam_pkg.sv =====
// Shared types, sizes and helper functions for the decimal add/multiply unit.
// Depends on nothing; every other file in the design imports this package.
package dam_pkg;

  localparam int DIGITS     = 16;
  localparam int DIGIT_W    = 4;
  localparam int OP_W       = 64;
  localparam int USED_W     = DIGITS * DIGIT_W;
  localparam int RES_DIGITS = 2 * DIGITS;
  localparam int RES_W      = RES_DIGITS * DIGIT_W;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_MUL = 1'b1;

  typedef struct packed {
    logic            func;
    logic [OP_W-1:0] operand_a;
    logic [OP_W-1:0] operand_b;
  } dam_req_t;

  typedef struct packed {
    logic [OP_W-1:0] result_low;
    logic [OP_W-1:0] result_high;
    logic            bad_digit;
  } dam_rsp_t;

  // Accumulator state handed from cell to cell. r holds one digit per position
  // and c holds the carry pending into each position (carry-save form).
  typedef struct packed {
    logic [RES_W-1:0]  a;
    logic [USED_W-1:0] b;
    logic [RES_W-1:0]  r;
    logic [RES_W-1:0]  c;
    logic              bad;
  } dam_stage_t;

  // Quotient of a value up to 99 by ten, through a multiply by 205/2048.
  function automatic logic [3:0] div10(input logic [6:0] t);
    logic [14:0] m;
    m = {8'd0, t} * 15'd205;
    return m[14:11];
  endfunction

  // True when every digit of the vector is a decimal digit.
  function automatic logic all_bcd(input logic [RES_W-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < RES_DIGITS; k++) begin
      if (v[k*DIGIT_W +: DIGIT_W] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== design/dam_cell.sv =====
// One row cell of the multiplier chain: adds one partial-product row into the
// carry-save accumulator and moves the carries one digit up. Uses dam_pkg.
module dam_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dam_pkg::dam_stage_t in_stage,
  output logic                out_valid,
  output dam_pkg::dam_stage_t out_stage
);
  import dam_pkg::*;

  logic       out_valid_r;
  dam_stage_t out_stage_r;
  dam_stage_t stage_nxt;

  always_comb begin
    logic [3:0] b_dig;
    logic [7:0] prod;
    logic [6:0] t;
    logic [3:0] q;
    logic [6:0] rem;
    b_dig           = in_stage.b[DIGIT_W-1:0];
    stage_nxt       = in_stage;
    stage_nxt.a     = in_stage.a << DIGIT_W;
    stage_nxt.b     = in_stage.b >> DIGIT_W;
    stage_nxt.c     = '0;
    for (int k = 0; k < RES_DIGITS; k++) begin
      prod = {4'd0, in_stage.a[k*DIGIT_W +: DIGIT_W]} * {4'd0, b_dig};
      t    = {3'd0, in_stage.r[k*DIGIT_W +: DIGIT_W]} + prod[6:0]
             + {3'd0, in_stage.c[k*DIGIT_W +: DIGIT_W]};
      q    = div10(t);
      rem  = t - {3'd0, q} * 7'd10;
      stage_nxt.r[k*DIGIT_W +: DIGIT_W] = rem[3:0];
      if (k < RES_DIGITS - 1) begin
        stage_nxt.c[(k+1)*DIGIT_W +: DIGIT_W] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage_r <= stage_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_stage = out_stage_r;

`ifndef SYNTH
  // The lowest position never has a carry pending after a cell.
  a_low_carry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stage.c[DIGIT_W-1:0] == '0)
    else $error("carry pending into the lowest digit");
  // Accumulator digits stay decimal after each row.
  a_digits_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> all_bcd(out_stage.r))
    else $error("accumulator digit out of range");
`endif

endmodule

// ===== design/dam_resolve.sv =====
// Final stage: folds the pending carries into the accumulator with a decimal
// carry-lookahead add and registers the result. Uses dam_pkg.
module dam_resolve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dam_pkg::dam_stage_t in_stage,
  output logic                out_valid,
  output dam_pkg::dam_rsp_t   out_rsp
);
  import dam_pkg::*;

  logic              out_valid_r;
  dam_rsp_t          out_rsp_r;
  dam_rsp_t          rsp_nxt;
  logic [RES_DIGITS-1:0] gen;
  logic [RES_DIGITS-1:0] prop;
  logic [RES_DIGITS-1:0] sum_gp;
  logic [RES_DIGITS-1:0] cin;
  logic [RES_W-1:0]      digits;
  logic [2*OP_W-1:0]     full;

  // Per digit, u = r + c is at most 18. A digit generates a carry at ten or
  // more and propagates one at exactly nine. The carry into every digit falls
  // out of one binary add of the generate and propagate vectors.
  always_comb begin
    logic [4:0] u;
    logic [4:0] v;
    for (int k = 0; k < RES_DIGITS; k++) begin
      u = {1'b0, in_stage.r[k*DIGIT_W +: DIGIT_W]} + {1'b0, in_stage.c[k*DIGIT_W +: DIGIT_W]};
      gen[k]  = (u >= 5'd10);
      prop[k] = (u == 5'd9);
    end
    sum_gp = (gen | prop) + gen;
    cin    = sum_gp ^ (gen | prop) ^ gen;
    for (int k = 0; k < RES_DIGITS; k++) begin
      u = {1'b0, in_stage.r[k*DIGIT_W +: DIGIT_W]} + {1'b0, in_stage.c[k*DIGIT_W +: DIGIT_W]};
      v = u + {4'd0, cin[k]};
      if (v >= 5'd10) begin
        v = v - 5'd10;
      end
      digits[k*DIGIT_W +: DIGIT_W] = v[3:0];
    end
    full                = (2*OP_W)'(digits);
    rsp_nxt.result_low  = full[OP_W-1:0];
    rsp_nxt.result_high = full[2*OP_W-1:OP_W];
    rsp_nxt.bad_digit   = in_stage.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTH
  // A flagged request always comes out as zero.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.bad_digit |->
      out_rsp.result_low == '0 && out_rsp.result_high == '0)
    else $error("nonzero result on a bad digit");
`endif

endmodule

// ===== design/decimal_add_multiply_unit.sv =====
// Top level of the decimal add/multiply unit: operand check and entry stage,
// the chain of row cells and the carry resolve stage. Uses dam_pkg,
// dam_cell and dam_resolve.
//
// The unit takes one request in every clock cycle: busy is always low, so a
// request is accepted at each rising edge where start is high. Each request
// gives exactly one result, shown on out_rsp for a single cycle with out_valid
// high. Each request is registered in the entry register, then in one row cell
// per multiplier digit, and last in the final carry resolve register. The
// receiver cannot hold results off, and results leave in request order.
// Operands are checked on entry: any nibble above nine in either operand sets
// bad_digit and the whole result reads zero. Add is run through the same
// chain as multiply, with operand a loaded as the accumulator and operand b as
// its pending carries, so the cells only move carries for an add.
module decimal_add_multiply_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dam_pkg::dam_req_t in_req,
  output logic              out_valid,
  output dam_pkg::dam_rsp_t out_rsp
);
  import dam_pkg::*;

  logic       entry_valid_r;
  dam_stage_t entry_stage_r;
  dam_stage_t entry_nxt;
  logic       bad;

  logic       chain_valid [DIGITS+1];
  dam_stage_t chain_stage [DIGITS+1];

  // The unit never stalls the sender.
  assign busy = 1'b0;

  // Only the low DIGITS nibbles of each operand are checked and used.
  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      if (in_req.operand_a[k*DIGIT_W +: DIGIT_W] > 4'd9 ||
          in_req.operand_b[k*DIGIT_W +: DIGIT_W] > 4'd9) begin
        bad = 1'b1;
      end
    end
  end

  // Build the starting accumulator. A bad request enters as all zeros, so the
  // chain naturally produces a zero result for it.
  always_comb begin
    entry_nxt     = '0;
    entry_nxt.bad = bad;
    if (!bad) begin
      if (in_req.func == FUNC_MUL) begin
        entry_nxt.a = RES_W'(in_req.operand_a[USED_W-1:0]);
        entry_nxt.b = in_req.operand_b[USED_W-1:0];
      end else begin
        entry_nxt.r = RES_W'(in_req.operand_a[USED_W-1:0]);
        entry_nxt.c = RES_W'(in_req.operand_b[USED_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else begin
      entry_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    entry_stage_r <= entry_nxt;
  end

  assign chain_valid[0] = entry_valid_r;
  assign chain_stage[0] = entry_stage_r;

  // One cell per digit of operand b; each adds its row and shifts a up a digit.
  for (genvar g = 0; g < DIGITS; g++) begin : g_row
    dam_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[g]),
      .in_stage  (chain_stage[g]),
      .out_valid (chain_valid[g+1]),
      .out_stage (chain_stage[g+1])
    );
  end

  dam_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[DIGITS]),
    .in_stage  (chain_stage[DIGITS]),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

`ifndef SYNTH
  // Every result traces back to a request accepted a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, DIGITS + 2))
    else $error("result without a matching request");
  // An accepted request always produces its result after the fixed latency.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    entry_valid_r |-> ##(DIGITS + 1) out_valid)
    else $error("request lost in the chain");
`endif

endmodule
